// ===== rtl/core/udp_payload_locator_defines.svh =====
// Assertion macros used by the UDP payload locator queue.
`ifndef UDP_PAYLOAD_LOCATOR_DEFINES_SVH
`define UDP_PAYLOAD_LOCATOR_DEFINES_SVH

// The condition must never hold at a clock edge outside reset.
`define UDPL_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the cycle after.
`define UDPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/udpl_pkg.sv =====
// Shared beat types and protocol constants for the UDP payload locator.
package udpl_pkg;

    // One input beat: a captured byte and its end-of-packet flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    // One result beat, produced on the last byte of each packet.
    typedef struct packed {
        logic        accepted;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } out_beat_t;

    // Link type register codes.
    localparam logic [2:0] LINK_ETHER   = 3'd0;
    localparam logic [2:0] LINK_COOKED1 = 3'd1;
    localparam logic [2:0] LINK_COOKED2 = 3'd2;
    localparam logic [2:0] LINK_RAW_IP  = 3'd3;

    // Protocol constants.
    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_TYPE_VLAN  = 16'h8100;
    localparam logic [15:0] ETH_TYPE_QINQ  = 16'h88a8;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [3:0]  IHL_MASK       = 4'hF;
    localparam int          ETH_TYPE_OFFS  = 12;
    localparam int          VLAN_TAG_LEN   = 4;
    localparam int          COOKED1_LEN    = 16;
    localparam int          COOKED2_LEN    = 20;
    localparam int          IP_MIN_HDR_LEN = 20;
    localparam int          UDP_HDR_LEN    = 8;
    localparam int          IP_PROTO_OFFS  = 9;
    localparam int          UDP_LEN_OFFS   = 4;

    // Bits of a packet summary record that do not scale with the position width:
    // mode 3, header found 1, ether type 16, header length 6, version 4,
    // protocol 8, UDP length 16.
    localparam int REC_FIXED_BITS = 54;

endpackage

// ===== rtl/core/udp_payload_locator.sv =====
// Top level of the UDP payload locator: parser, summary queue and decision stage.
//
//   channel  direction  payload                                  handshake
//   item     in         data_byte, last_byte                     item_valid / item_stall
//   result   out        accepted, payload_offset, payload_length result_valid / result_stall
//   cfg      in         link mode (3 bits)                       cfg_wr_en
//
// One byte beat is taken every cycle while item_stall is low; the parser's position
// compares and field captures finish within the cycle of the byte.
// After the last byte, the result beat passes through the summary queue and then the output register.
// Reset clears all parse state and the link mode to Ethernet; there is no clearing pass.
// The item channel stalls only when two summaries are queued behind a result
// that is itself held by a stall on the result channel.
module udp_payload_locator #(
    parameter int LEN_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    input  logic                item_valid,
    output logic                item_stall,
    input  udpl_pkg::in_beat_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output udpl_pkg::out_beat_t result
);
    import udpl_pkg::*;

    localparam int REC_W = 2 * LEN_BITS + REC_FIXED_BITS;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [REC_W-1:0] q_rec;
    logic [REC_W-1:0] q_head;

    // Front: byte parser.
    udpl_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (q_rec)
    );

    // Queue of packet summaries.
    udpl_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_rec),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: decision and result register.
    udpl_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/core/udpl_front.sv =====
// Byte-stream header parser that emits one summary record per packet.
module udpl_front #(
    parameter int LEN_BITS = 16,
    localparam int REC_W = 2 * LEN_BITS + udpl_pkg::REC_FIXED_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  udpl_pkg::in_beat_t item,
    input  logic               q_full,
    output logic               q_push,
    output logic [REC_W-1:0]   q_rec
);
    import udpl_pkg::*;

    localparam logic [LEN_BITS-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [2:0]          mode;
        logic                hdr_done;
        logic [15:0]         ether_type;
        logic [LEN_BITS-1:0] ip_start;
        logic [5:0]          ihl_bytes;
        logic [3:0]          version;
        logic [7:0]          protocol;
        logic [15:0]         udp_len;
        logic [LEN_BITS-1:0] total;
    } rec_t;

    logic [2:0]          link_mode_reg;
    logic [2:0]          mode_reg,      mode_next,      mode_upd;
    logic [LEN_BITS-1:0] byte_pos_reg,  byte_pos_next,  byte_pos_upd;
    logic [LEN_BITS-1:0] type_pos_reg,  type_pos_next,  type_pos_upd;
    logic [LEN_BITS-1:0] ip_start_reg,  ip_start_next,  ip_start_upd;
    logic [7:0]          held_reg,      held_next,      held_upd;
    logic [15:0]         ether_reg,     ether_next,     ether_upd;
    logic [3:0]          version_reg,   version_next,   version_upd;
    logic [5:0]          ihl_reg,       ihl_next,       ihl_upd;
    logic [7:0]          proto_reg,     proto_next,     proto_upd;
    logic [15:0]         udp_len_reg,   udp_len_next,   udp_len_upd;
    logic                hdr_done_reg,  hdr_done_next,  hdr_done_upd;

    logic                accept;
    logic                first;
    logic                active;
    logic [LEN_BITS:0]   type_pos_p1;
    logic [LEN_BITS:0]   type_pos_p4;
    logic [LEN_BITS-1:0] rel;
    logic [LEN_BITS-1:0] udp_hi_rel;
    logic [LEN_BITS-1:0] udp_lo_rel;
    logic [15:0]         type_word;
    rec_t                rec;

    // The input stalls only while the summary queue has no room.
    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;

    // Link type register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_mode_reg <= LINK_ETHER;
        end
        else if (cfg_wr_en)
        begin
            link_mode_reg <= cfg_wr_data;
        end
    end

    assign first       = (byte_pos_reg == '0);
    assign active      = (byte_pos_reg != POS_MAX);
    assign type_pos_p1 = {1'b0, type_pos_reg} + (LEN_BITS+1)'(1);
    assign type_pos_p4 = {1'b0, type_pos_reg} + (LEN_BITS+1)'(VLAN_TAG_LEN);
    assign udp_hi_rel  = LEN_BITS'(ihl_reg) + LEN_BITS'(UDP_LEN_OFFS);
    assign udp_lo_rel  = LEN_BITS'(ihl_reg) + LEN_BITS'(UDP_LEN_OFFS + 1);
    assign type_word   = {held_reg, item.data_byte};

    // Effect of one byte on the parse state.
    always_comb
    begin
        mode_upd     = first ? link_mode_reg : mode_reg;
        byte_pos_upd = active ? byte_pos_reg + LEN_BITS'(1) : byte_pos_reg;
        type_pos_upd = type_pos_reg;
        ip_start_upd = ip_start_reg;
        held_upd     = held_reg;
        ether_upd    = ether_reg;
        version_upd  = version_reg;
        ihl_upd      = ihl_reg;
        proto_upd    = proto_reg;
        udp_len_upd  = udp_len_reg;
        hdr_done_upd = hdr_done_reg;
        rel          = '0;

        // Fixed-length link headers locate the IP header on the first byte.
        if (active && first)
        begin
            unique case (mode_upd)
                LINK_COOKED1:
                begin
                    ip_start_upd = LEN_BITS'(COOKED1_LEN);
                    hdr_done_upd = 1'b1;
                end
                LINK_COOKED2:
                begin
                    ip_start_upd = LEN_BITS'(COOKED2_LEN);
                    hdr_done_upd = 1'b1;
                end
                LINK_RAW_IP:
                begin
                    ip_start_upd = '0;
                    hdr_done_upd = 1'b1;
                end
                default:
                begin
                    hdr_done_upd = hdr_done_reg;
                end
            endcase
        end

        if (active)
        begin
            // Ethernet: walk the type words, skipping VLAN tags.
            if (mode_upd == LINK_ETHER && !hdr_done_upd)
            begin
                if ({1'b0, byte_pos_reg} == {1'b0, type_pos_reg})
                begin
                    held_upd = item.data_byte;
                end
                else if ({1'b0, byte_pos_reg} == type_pos_p1)
                begin
                    ether_upd = type_word;
                    if (type_word == ETH_TYPE_VLAN || type_word == ETH_TYPE_QINQ)
                    begin
                        type_pos_upd = (type_pos_p4 > {1'b0, POS_MAX}) ?
                                       POS_MAX : type_pos_p4[LEN_BITS-1:0];
                    end
                    else
                    begin
                        hdr_done_upd = 1'b1;
                        ip_start_upd = byte_pos_reg + LEN_BITS'(1);
                    end
                end
            end
            // IP and UDP header field captures relative to the IP start.
            else if (hdr_done_upd && byte_pos_reg >= ip_start_upd)
            begin
                rel = byte_pos_reg - ip_start_upd;
                if (rel == '0)
                begin
                    version_upd = item.data_byte[7:4];
                    ihl_upd     = {item.data_byte[3:0] & IHL_MASK, 2'b00};
                end
                if (rel == LEN_BITS'(IP_PROTO_OFFS))
                begin
                    proto_upd = item.data_byte;
                end
                if (rel == udp_hi_rel)
                begin
                    udp_len_upd[15:8] = item.data_byte;
                end
                if (rel == udp_lo_rel)
                begin
                    udp_len_upd[7:0] = item.data_byte;
                end
            end
        end
    end

    // Summary of the packet as it stands after the last byte.
    always_comb
    begin
        rec.mode       = mode_upd;
        rec.hdr_done   = hdr_done_upd;
        rec.ether_type = ether_upd;
        rec.ip_start   = ip_start_upd;
        rec.ihl_bytes  = ihl_upd;
        rec.version    = version_upd;
        rec.protocol   = proto_upd;
        rec.udp_len    = udp_len_upd;
        rec.total      = active ? byte_pos_reg + LEN_BITS'(1) : POS_MAX;
    end

    assign q_push = accept && item.last_byte;
    assign q_rec  = rec;

    // Next state: hold, advance, or clear at the end of a packet.
    always_comb
    begin
        mode_next     = mode_reg;
        byte_pos_next = byte_pos_reg;
        type_pos_next = type_pos_reg;
        ip_start_next = ip_start_reg;
        held_next     = held_reg;
        ether_next    = ether_reg;
        version_next  = version_reg;
        ihl_next      = ihl_reg;
        proto_next    = proto_reg;
        udp_len_next  = udp_len_reg;
        hdr_done_next = hdr_done_reg;
        if (accept && item.last_byte)
        begin
            mode_next     = LINK_ETHER;
            byte_pos_next = '0;
            type_pos_next = LEN_BITS'(ETH_TYPE_OFFS);
            ip_start_next = '0;
            held_next     = '0;
            ether_next    = '0;
            version_next  = '0;
            ihl_next      = '0;
            proto_next    = '0;
            udp_len_next  = '0;
            hdr_done_next = 1'b0;
        end
        else if (accept)
        begin
            mode_next     = mode_upd;
            byte_pos_next = byte_pos_upd;
            type_pos_next = type_pos_upd;
            ip_start_next = ip_start_upd;
            held_next     = held_upd;
            ether_next    = ether_upd;
            version_next  = version_upd;
            ihl_next      = ihl_upd;
            proto_next    = proto_upd;
            udp_len_next  = udp_len_upd;
            hdr_done_next = hdr_done_upd;
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= LINK_ETHER;
            byte_pos_reg <= '0;
            type_pos_reg <= LEN_BITS'(ETH_TYPE_OFFS);
            ip_start_reg <= '0;
            held_reg     <= '0;
            ether_reg    <= '0;
            version_reg  <= '0;
            ihl_reg      <= '0;
            proto_reg    <= '0;
            udp_len_reg  <= '0;
            hdr_done_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            byte_pos_reg <= byte_pos_next;
            type_pos_reg <= type_pos_next;
            ip_start_reg <= ip_start_next;
            held_reg     <= held_next;
            ether_reg    <= ether_next;
            version_reg  <= version_next;
            ihl_reg      <= ihl_next;
            proto_reg    <= proto_next;
            udp_len_reg  <= udp_len_next;
            hdr_done_reg <= hdr_done_next;
        end
    end

endmodule

// ===== rtl/core/udpl_queue.sv =====
// Two-entry queue of packet summary records between the parser and the decision stage.
module udpl_queue #(
    parameter int WIDTH = 86
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);
    `include "udp_payload_locator_defines.svh"

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `UDPL_ASSERT_NEVER(a_push_when_full, push && full, "record pushed into a full queue")
    `UDPL_ASSERT_NEVER(a_pop_when_empty, pop && empty, "record popped from an empty queue")
    `UDPL_ASSERT_NEVER(a_count_range, count_reg > CNT_W'(DEPTH), "queue fill count out of range")
    `UDPL_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "fill count did not follow a push")

endmodule

// ===== rtl/core/udpl_back.sv =====
// Accept decision, offset and length clamp, and the registered result beat.
module udpl_back #(
    parameter int LEN_BITS = 16,
    localparam int REC_W = 2 * LEN_BITS + udpl_pkg::REC_FIXED_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REC_W-1:0]    q_head,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output udpl_pkg::out_beat_t result
);
    import udpl_pkg::*;

    localparam int XW = LEN_BITS + 1;
    localparam int CW = (XW > 16) ? XW : 16;

    typedef struct packed {
        logic [2:0]          mode;
        logic                hdr_done;
        logic [15:0]         ether_type;
        logic [LEN_BITS-1:0] ip_start;
        logic [5:0]          ihl_bytes;
        logic [3:0]          version;
        logic [7:0]          protocol;
        logic [15:0]         udp_len;
        logic [LEN_BITS-1:0] total;
    } rec_t;

    rec_t            rec;
    logic [XW-1:0]   total_x;
    logic [XW-1:0]   ip_min_end;
    logic [XW-1:0]   off;
    logic [XW-1:0]   avail;
    logic [CW-1:0]   off_c;
    logic [CW-1:0]   want_c;
    logic [CW-1:0]   avail_c;
    logic [15:0]     want;
    logic            ok;
    out_beat_t       beat;

    logic            valid_reg;
    out_beat_t       beat_reg;

    assign rec        = q_head;
    assign total_x    = {1'b0, rec.total};
    assign ip_min_end = {1'b0, rec.ip_start} + XW'(IP_MIN_HDR_LEN);
    assign off        = {1'b0, rec.ip_start} + XW'(rec.ihl_bytes) + XW'(UDP_HDR_LEN);
    assign avail      = total_x - off;
    assign want       = rec.udp_len - 16'(UDP_HDR_LEN);
    assign off_c      = CW'(off);
    assign want_c     = CW'(want);
    assign avail_c    = CW'(avail);

    // Header checks for an IPv4 UDP packet with enough captured bytes.
    always_comb
    begin
        ok = (rec.mode <= LINK_RAW_IP) && rec.hdr_done
             && !(rec.mode == LINK_ETHER && rec.ether_type != ETH_TYPE_IPV4)
             && (total_x >= ip_min_end)
             && (rec.version == IP_VERSION_4)
             && (total_x >= off)
             && (rec.protocol == IP_PROTO_UDP)
             && (rec.udp_len >= 16'(UDP_HDR_LEN));
    end

    // Result fields; a rejected packet reports zeros.
    always_comb
    begin
        beat.accepted       = ok;
        beat.payload_offset = '0;
        beat.payload_length = '0;
        if (ok)
        begin
            beat.payload_offset = (off_c > CW'(16'hFFFF)) ? 16'hFFFF : off_c[15:0];
            beat.payload_length = (want_c < avail_c) ? want : avail_c[15:0];
        end
    end

    // The output register takes a record when it is empty or being drained.
    assign q_pop = !q_empty && (!valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !result_stall)
        begin
            valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            beat_reg <= beat;
        end
    end

    assign result_valid = valid_reg;
    assign result       = beat_reg;

endmodule

// ===== tb/payload_locator_checker.sv =====
// Checker for the UDP payload locator: predicts packet verdicts and checks each result beat.
`timescale 1ns / 1ps

module payload_locator_checker
    import udpl_pkg::*;
#(
    parameter int LEN_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    input  logic      item_valid,
    input  logic      item_stall,
    input  in_beat_t  item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_beat_t result,
    output int        fail_count,
    output int        verdicts_due
);

    localparam int unsigned POS_LIMIT = (2 ** LEN_BITS) - 1;
    localparam int unsigned OUT_MAX   = 65535;

    // Link type register and the copy taken at the first byte of each packet.
    logic [2:0]          link_mode;
    logic [2:0]          pkt_mode;

    // Per-packet parse state.
    logic [LEN_BITS-1:0] seen_bytes;
    logic [LEN_BITS-1:0] type_at;
    logic [LEN_BITS-1:0] l3_start;
    logic [7:0]          type_hi;
    logic [15:0]         link_type;
    logic [3:0]          ip_ver;
    logic [5:0]          ip_hdr_bytes;
    logic [7:0]          ip_proto;
    logic [15:0]         udp_len;
    logic                l3_found;

    // Verdicts predicted for packets whose result beat has not yet been seen.
    out_beat_t           verdicts[$];
    int                  failures = 0;
    int                  due = 0;
    int                  beat_idx = 0;

    assign fail_count   = failures;
    assign verdicts_due = due;

    task automatic report_mismatch(input string msg);
        $display("result beat %0d: %s", beat_idx, msg);
        failures++;
    endtask

    function automatic void clear_packet();
        seen_bytes   = '0;
        type_at      = ETH_TYPE_OFFS;
        l3_start     = '0;
        type_hi      = '0;
        link_type    = '0;
        ip_ver       = '0;
        ip_hdr_bytes = '0;
        ip_proto     = '0;
        udp_len      = '0;
        l3_found     = 1'b0;
        pkt_mode     = LINK_ETHER;
    endfunction

    // Advance the parse by one byte; returns 1 with the verdict on the last byte.
    function automatic bit locate_payload(input in_beat_t b, output out_beat_t v);
        int unsigned p;
        int unsigned rel;
        int unsigned nxt;
        int unsigned total;
        int unsigned off;
        int unsigned want;
        int unsigned avail;
        bit          ok;
        p = seen_bytes;
        v = '0;
        if (p == 0)
            pkt_mode = link_mode;

        if (p < POS_LIMIT)
        begin
            // Fixed-length link headers locate the IP header at once.
            if (p == 0)
            begin
                case (pkt_mode)
                    LINK_COOKED1:
                    begin
                        l3_start = COOKED1_LEN;
                        l3_found = 1'b1;
                    end
                    LINK_COOKED2:
                    begin
                        l3_start = COOKED2_LEN;
                        l3_found = 1'b1;
                    end
                    LINK_RAW_IP:
                    begin
                        l3_start = '0;
                        l3_found = 1'b1;
                    end
                    default: ;
                endcase
            end

            if (pkt_mode == LINK_ETHER && !l3_found)
            begin
                // Walk the type words, skipping over any VLAN tags.
                if (p == type_at)
                    type_hi = b.data_byte;
                else if (p == type_at + 1)
                begin
                    link_type = {type_hi, b.data_byte};
                    if (link_type == ETH_TYPE_VLAN || link_type == ETH_TYPE_QINQ)
                    begin
                        nxt = type_at + VLAN_TAG_LEN;
                        type_at = (nxt > POS_LIMIT) ? POS_LIMIT : nxt;
                    end
                    else
                    begin
                        l3_found = 1'b1;
                        l3_start = p + 1;
                    end
                end
            end
            else if (l3_found && p >= l3_start)
            begin
                // Capture the IP and UDP header fields by offset from the IP start.
                rel = p - l3_start;
                if (rel == 0)
                begin
                    ip_ver       = b.data_byte[7:4];
                    ip_hdr_bytes = {b.data_byte[3:0] & IHL_MASK, 2'b00};
                end
                if (rel == IP_PROTO_OFFS)
                    ip_proto = b.data_byte;
                if (rel == ip_hdr_bytes + UDP_LEN_OFFS)
                    udp_len[15:8] = b.data_byte;
                if (rel == ip_hdr_bytes + UDP_LEN_OFFS + 1)
                    udp_len[7:0] = b.data_byte;
            end
            seen_bytes = p + 1;
        end

        if (!b.last_byte)
            return 1'b0;

        // Decide the packet on its last byte.
        total = (p + 1 > POS_LIMIT) ? POS_LIMIT : p + 1;
        off   = l3_start + ip_hdr_bytes + UDP_HDR_LEN;
        ok    = (pkt_mode <= LINK_RAW_IP) && l3_found;
        if (ok && pkt_mode == LINK_ETHER && link_type != ETH_TYPE_IPV4)
            ok = 1'b0;
        if (ok && total < l3_start + IP_MIN_HDR_LEN)
            ok = 1'b0;
        if (ok && ip_ver != IP_VERSION_4)
            ok = 1'b0;
        if (ok && total < off)
            ok = 1'b0;
        if (ok && ip_proto != IP_PROTO_UDP)
            ok = 1'b0;
        if (ok && udp_len < UDP_HDR_LEN)
            ok = 1'b0;
        if (ok)
        begin
            want  = udp_len - UDP_HDR_LEN;
            avail = total - off;
            if (avail < want)
                want = avail;
            v.accepted       = 1'b1;
            v.payload_offset = (off > OUT_MAX) ? OUT_MAX : off;
            v.payload_length = (want > OUT_MAX) ? OUT_MAX : want;
        end
        clear_packet();
        return 1'b1;
    endfunction

    // Watch the three ports: result beats are checked, byte beats feed the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t v;
        out_beat_t exp_beat;
        if (!rst_n)
        begin
            link_mode = LINK_ETHER;
            clear_packet();
            verdicts.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (verdicts.size() == 0)
                    report_mismatch("result beat with no packet outstanding");
                else
                begin
                    exp_beat = verdicts.pop_front();
                    if (result.accepted !== exp_beat.accepted)
                        report_mismatch($sformatf("accepted got %0d, expected %0d",
                                                  result.accepted, exp_beat.accepted));
                    if (result.payload_offset !== exp_beat.payload_offset)
                        report_mismatch($sformatf("payload_offset got %0d, expected %0d",
                                                  result.payload_offset,
                                                  exp_beat.payload_offset));
                    if (result.payload_length !== exp_beat.payload_length)
                        report_mismatch($sformatf("payload_length got %0d, expected %0d",
                                                  result.payload_length,
                                                  exp_beat.payload_length));
                end
                beat_idx++;
            end
            if (item_valid && !item_stall)
            begin
                if (locate_payload(item, v))
                    verdicts.push_back(v);
            end
            if (cfg_wr_en)
                link_mode = cfg_wr_data;
        end
        due = verdicts.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the UDP payload locator: clock, reset, packet stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import udpl_pkg::*;

    localparam int         LEN_BITS       = 16;
    localparam logic [2:0] LINK_UNSUPP_LO = 3'd4;
    localparam logic [2:0] LINK_UNSUPP_HI = 3'd7;
    localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86dd;
    localparam logic [7:0] IP_PROTO_TCP   = 8'd6;
    localparam logic [3:0] IP_VERSION_6   = 4'd6;
    localparam logic [3:0] IHL_MIN        = 4'd5;
    localparam int         IDLE_PCT       = 19;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         LONG_FRAME     = 65540;
    localparam int         CYCLE_LIMIT    = 1000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [2:0] cfg_wr_data = LINK_ETHER;
    logic       item_valid = 1'b0;
    logic       item_stall;
    in_beat_t   item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    out_beat_t  result;

    int         fail_count;
    int         verdicts_due;
    bit         quiet = 1'b0;
    logic       hold_req = 1'b0;
    int         hold_left = 0;
    int         cycles = 0;
    logic [7:0] frame[$];

    udp_payload_locator #(
        .LEN_BITS(LEN_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    payload_locator_checker #(
        .LEN_BITS(LEN_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .fail_count  (fail_count),
        .verdicts_due(verdicts_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("udp_payload_locator regression: fail");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when asked for one.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            result_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else
            result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic logic [7:0] rand_byte();
        return $urandom_range(255);
    endfunction

    // Assemble a packet: link header for the mode, then an IPv4 header and UDP header.
    function automatic void build_frame(input logic [2:0] mode, input int tags,
                                        input logic [15:0] etype, input logic [7:0] ver_ihl,
                                        input logic [7:0] proto, input logic [15:0] ulen,
                                        input int payload, input int keep);
        int          hdr;
        int          l3_len;
        logic [15:0] tag;
        logic [7:0]  l3[$];
        frame.delete();
        case (mode)
            LINK_COOKED1: repeat (COOKED1_LEN) frame.push_back(rand_byte());
            LINK_COOKED2: repeat (COOKED2_LEN) frame.push_back(rand_byte());
            LINK_RAW_IP: ;
            default:
            begin
                repeat (ETH_TYPE_OFFS) frame.push_back(rand_byte());
                repeat (tags)
                begin
                    tag = $urandom_range(1) ? ETH_TYPE_VLAN : ETH_TYPE_QINQ;
                    frame.push_back(tag[15:8]);
                    frame.push_back(tag[7:0]);
                    frame.push_back(rand_byte());
                    frame.push_back(rand_byte());
                end
                frame.push_back(etype[15:8]);
                frame.push_back(etype[7:0]);
            end
        endcase
        hdr = 4 * ver_ihl[3:0];
        l3_len = (hdr + UDP_HDR_LEN > IP_MIN_HDR_LEN) ? hdr + UDP_HDR_LEN : IP_MIN_HDR_LEN;
        l3_len = l3_len + payload;
        repeat (l3_len) l3.push_back(rand_byte());
        // With a small IHL the UDP length may land inside the IP header.
        l3[0] = ver_ihl;
        l3[IP_PROTO_OFFS] = proto;
        l3[hdr + UDP_LEN_OFFS] = ulen[15:8];
        l3[hdr + UDP_LEN_OFFS + 1] = ulen[7:0];
        foreach (l3[i])
            frame.push_back(l3[i]);
        if (keep > 0)
            while (frame.size() > keep)
                void'(frame.pop_back());
    endfunction

    function automatic void noise_frame(input int len);
        frame.delete();
        repeat (len) frame.push_back(rand_byte());
    endfunction

    function automatic void fill_frame(input logic [7:0] value, input int len);
        frame.delete();
        repeat (len) frame.push_back(value);
    endfunction

    // Mostly well-formed packets with random content; the rest malformed or plain noise.
    function automatic void random_frame(input logic [2:0] mode);
        int          payload;
        int          tags;
        int          keep;
        int          r;
        logic [15:0] etype;
        logic [15:0] ulen;
        logic [7:0]  vi;
        logic [7:0]  proto;
        logic [7:0]  tmp;
        if ($urandom_range(99) < 20)
        begin
            noise_frame($urandom_range(1, 70));
            return;
        end
        payload = $urandom_range(0, 40);
        tags = ($urandom_range(99) < 50) ? 0 : $urandom_range(1, 3);
        etype = ($urandom_range(99) < 90) ? ETH_TYPE_IPV4 : {rand_byte(), rand_byte()};
        tmp = rand_byte();
        r = $urandom_range(99);
        if (r < 80)
            vi = {IP_VERSION_4, IHL_MIN};
        else if (r < 90)
            vi = {IP_VERSION_4, tmp[3:0]};
        else
            vi = tmp;
        proto = ($urandom_range(99) < 85) ? IP_PROTO_UDP : rand_byte();
        r = $urandom_range(99);
        if (r < 75)
            ulen = UDP_HDR_LEN + payload;
        else if (r < 90)
            ulen = UDP_HDR_LEN + payload + $urandom_range(1, 30);
        else
            ulen = {rand_byte(), rand_byte()};
        keep = ($urandom_range(99) < 15) ? $urandom_range(1, 60) : -1;
        build_frame(mode, tags, etype, vi, proto, ulen, payload, keep);
    endfunction

    // Offer one byte beat, with random idle cycles ahead of it, and wait for it to be taken.
    task automatic send_byte(input logic [7:0] d, input logic last);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{data_byte: d, last_byte: last};
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic send_part(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    task automatic send_frame();
        send_part(0, frame.size());
    endtask

    // Stop sending and wait until every result has come out and the pipeline is quiet.
    task automatic settle();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (verdicts_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_link(input logic [2:0] mode);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        // Plain Ethernet at the reset link type, then VLAN and QinQ stacks, and a non-IPv4 ether type.
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd18, 10, -1);
        send_frame();
        build_frame(LINK_ETHER, 1, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd12, 4, -1);
        send_frame();
        build_frame(LINK_ETHER, 3, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd20, 12, -1);
        send_frame();
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV6, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd16, 8, -1);
        send_frame();

        // Header lengths below the minimum, and the largest one.
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, 4'h0}, IP_PROTO_UDP,
                    16'd16, 6, -1);
        send_frame();
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, 4'h2}, IP_PROTO_UDP,
                    16'd16, 6, -1);
        send_frame();
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MASK}, IP_PROTO_UDP,
                    16'd24, 16, -1);
        send_frame();

        // Wrong IP version and a non-UDP protocol.
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_6, IHL_MIN}, IP_PROTO_UDP,
                    16'd16, 8, -1);
        send_frame();
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_TCP,
                    16'd16, 8, -1);
        send_frame();

        // UDP length below, at and far above the UDP header size.
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd7, 4, -1);
        send_frame();
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd8, 0, -1);
        send_frame();
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'hFFFF, 20, -1);
        send_frame();

        // Captures cut short inside the IP header and inside the UDP header.
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd16, 8, 30);
        send_frame();
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd16, 8, 38);
        send_frame();

        // A one-byte packet, then packets of all ones and all zeros.
        fill_frame(8'h00, 1);
        send_frame();
        fill_frame(8'hFF, 60);
        send_frame();
        fill_frame(8'h00, 60);
        send_frame();

        // Each link type, the unsupported codes at both ends among them.
        settle();
        set_link(LINK_COOKED1);
        build_frame(LINK_COOKED1, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd14, 6, -1);
        send_frame();
        settle();
        set_link(LINK_COOKED2);
        build_frame(LINK_COOKED2, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd14, 6, -1);
        send_frame();
        settle();
        set_link(LINK_UNSUPP_LO);
        build_frame(LINK_ETHER, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd14, 6, -1);
        send_frame();
        settle();
        set_link(LINK_UNSUPP_HI);
        send_frame();

        // A mode change in the middle of a packet only takes effect from the next one.
        settle();
        set_link(LINK_RAW_IP);
        build_frame(LINK_RAW_IP, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd20, 12, -1);
        send_part(0, 10);
        settle();
        set_link(LINK_ETHER);
        send_part(10, frame.size());
        build_frame(LINK_ETHER, 2, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'd20, 12, -1);
        send_frame();

        // A VLAN chain that runs past the counted range is never resolved.
        frame.delete();
        for (int i = 0; i < LONG_FRAME; i++)
        begin
            if (i < ETH_TYPE_OFFS)
                frame.push_back(rand_byte());
            else if ((i - ETH_TYPE_OFFS) % VLAN_TAG_LEN == 0)
                frame.push_back(ETH_TYPE_VLAN[15:8]);
            else if ((i - ETH_TYPE_OFFS) % VLAN_TAG_LEN == 1)
                frame.push_back(ETH_TYPE_VLAN[7:0]);
            else
                frame.push_back(rand_byte());
        end
        send_frame();

        // A raw IP packet longer than the counted range: payload length is clamped.
        settle();
        set_link(LINK_RAW_IP);
        build_frame(LINK_RAW_IP, 0, ETH_TYPE_IPV4, {IP_VERSION_4, IHL_MIN}, IP_PROTO_UDP,
                    16'hFFFF, LONG_FRAME - IP_MIN_HDR_LEN - UDP_HDR_LEN, -1);
        send_frame();
    endtask

    // Hold the result side off while short packets keep arriving, so the input backs up.
    task automatic apply_pressure();
        settle();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (30)
        begin
            noise_frame($urandom_range(1, 3));
            send_frame();
        end
    endtask

    task automatic run_random();
        logic [2:0] plan[8];
        int         sent_bytes;
        int         sent_pkts;
        plan[0] = LINK_ETHER;
        plan[1] = LINK_COOKED1;
        plan[2] = LINK_RAW_IP;
        plan[3] = LINK_ETHER;
        plan[4] = LINK_COOKED2;
        plan[5] = LINK_UNSUPP_HI;
        plan[6] = LINK_ETHER;
        plan[7] = LINK_RAW_IP;
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            set_link(plan[ph]);
            // One phase runs with no idling on either side.
            quiet = (ph == 3);
            sent_bytes = 0;
            sent_pkts = 0;
            while (sent_bytes < 100 || sent_pkts < 8)
            begin
                random_frame(plan[ph]);
                send_frame();
                sent_bytes += frame.size();
                sent_pkts++;
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        apply_pressure();
        run_random();
        settle();
        @(negedge clk);
        if (fail_count == 0)
            $display("udp_payload_locator regression: pass");
        else
            $display("udp_payload_locator regression: fail");
        $finish;
    end

endmodule
